// ----- hw/rtl/klst_pkg.sv -----
// Shared types, constants and helpers for the k-th largest stream tracker.
// No dependencies; imported by klst_cell, the top level and its checker.
package klst_pkg;

    localparam int VALUE_W    = 32;
    localparam int RANK_W     = 5;
    localparam int RANK_RESET = 1;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [RANK_W-1:0]         t_rank;

    // Signed order: a kept value at or above the new one stays in front of it
    function automatic logic value_ge(input t_value a, input t_value b);
        value_ge = (a >= b);
    endfunction

endpackage

// ----- hw/rtl/klst_cell.sv -----
// One position of the sorted chain of kept values (descending order).
// Depends on klst_pkg; instantiated once per rank slot by the top level.
module klst_cell (
    input  logic                 i_clk,
    input  logic                 i_load,       // commit the insertion candidate this cycle
    input  klst_pkg::t_value     i_new_value,  // value being inserted
    input  logic                 i_valid,      // this slot holds a kept value
    input  logic                 i_prev_ge,    // neighbour in front stays ahead of new value
    input  klst_pkg::t_value     i_prev_value, // neighbour in front, shifted in on insert
    output logic                 o_ge,
    output klst_pkg::t_value     o_value,
    output klst_pkg::t_value     o_cand        // contents of this slot if the insert commits
);
    import klst_pkg::*;

    t_value r_value;

    assign o_value = r_value;
    assign o_ge    = i_valid && value_ge(r_value, i_new_value);

    // Hold own value, take the new one at the boundary, or shift the neighbour down
    always_comb begin
        if (o_ge) begin
            o_cand = r_value;
        end else if (i_prev_ge) begin
            o_cand = i_new_value;
        end else begin
            o_cand = i_prev_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= o_cand;
        end
    end

endmodule

// ----- hw/rtl/kth_largest_stream_tracker.sv -----
// Top level of the k-th largest stream tracker: a chain of compare cells
// holding the kept values sorted, plus the rank register and result stage.
// Depends on klst_pkg and klst_cell.
// Result: the result of an item is registered and shown in the cycle after its transaction.
// Throughput: one item per cycle unless results stall; cells compare and shift in parallel.
// Reset (synchronous, active low): kept count to zero, rank_k to 1, no result.
module kth_largest_stream_tracker #(
    parameter int MAX_RANK = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: rank_k
    input  logic                          i_cfg_we,
    input  logic [klst_pkg::RANK_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [klst_pkg::VALUE_W-1:0]  s_axis_tdata,  // [31:0] value
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [klst_pkg::VALUE_W-1:0]  m_axis_tdata,  // [31:0] kth_value
    output logic [0:0]                    m_axis_tuser   // [0] is_full
);
    import klst_pkg::*;

    // Count width holds MAX_RANK itself; index width addresses the slots
    localparam int KW = $clog2(MAX_RANK + 1);
    localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CW = (KW > RANK_W) ? KW : RANK_W;

    t_rank           r_rank;
    logic [KW-1:0]   r_count;
    logic [KW-1:0]   n_count;
    logic            r_m_valid;
    t_value          r_m_kth;
    logic            r_m_full;

    logic [CW-1:0]   rank_cw;
    logic [CW-1:0]   keff_cw;
    logic [KW-1:0]   keff;
    logic [KW-1:0]   keff_m1;
    logic [KW-1:0]   cnt_clamp;
    logic [KW-1:0]   n_count_m1;
    logic            full_now;
    logic            tail_ge;
    logic            do_insert;
    logic            in_xact;
    logic            load_en;
    t_value          new_value;

    logic   [MAX_RANK-1:0] cell_valid;
    logic   [MAX_RANK-1:0] cell_ge;
    t_value                cell_value [MAX_RANK];
    t_value                cell_cand  [MAX_RANK];

    // ---------------------------------------------------------------
    // Effective rank: zero reads as one, anything past MAX_RANK saturates
    // ---------------------------------------------------------------
    always_comb begin
        rank_cw = CW'(r_rank);
        if (rank_cw == '0) begin
            keff_cw = CW'(1);
        end else if (rank_cw > CW'(MAX_RANK)) begin
            keff_cw = CW'(MAX_RANK);
        end else begin
            keff_cw = rank_cw;
        end
        keff    = keff_cw[KW-1:0];
        keff_m1 = keff - KW'(1);
    end

    // A lowered rank drops the smallest entries before the item is handled
    assign cnt_clamp = (r_count > keff) ? keff : r_count;
    assign full_now  = (cnt_clamp == keff);

    // Tail compare: when full, the last kept slot decides whether to replace it
    assign tail_ge   = cell_ge[keff_m1[IW-1:0]];
    assign do_insert = !full_now || !tail_ge;

    always_comb begin
        if (!do_insert) begin
            n_count = cnt_clamp;
        end else if (full_now) begin
            n_count = keff;
        end else begin
            n_count = cnt_clamp + KW'(1);
        end
        n_count_m1 = n_count - KW'(1);
    end

    // ---------------------------------------------------------------
    // Handshake: the result register parts the two sides
    // ---------------------------------------------------------------
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign in_xact       = s_axis_tvalid && s_axis_tready;

    assign load_en   = in_xact && do_insert;
    assign new_value = t_value'(s_axis_tdata);

    // ---------------------------------------------------------------
    // Chain of cells, largest value at slot 0
    // ---------------------------------------------------------------
    for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
        logic   prev_ge;
        t_value prev_value;

        assign cell_valid[g] = (KW'(g) < cnt_clamp);

        if (g == 0) begin : g_head
            // nothing ahead of the head: the new value may always land here
            assign prev_ge    = 1'b1;
            assign prev_value = new_value;
        end else begin : g_body
            assign prev_ge    = cell_ge[g-1];
            assign prev_value = cell_value[g-1];
        end

        klst_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (load_en),
            .i_new_value  (new_value),
            .i_valid      (cell_valid[g]),
            .i_prev_ge    (prev_ge),
            .i_prev_value (prev_value),
            .o_ge         (cell_ge[g]),
            .o_value      (cell_value[g]),
            .o_cand       (cell_cand[g])
        );
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank    <= RANK_W'(RANK_RESET);
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rank <= i_cfg_wdata;
            end
            if (in_xact) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload: smallest kept value after this transaction
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_m_kth  <= do_insert ? cell_cand[n_count_m1[IW-1:0]]
                                  : cell_value[n_count_m1[IW-1:0]];
            r_m_full <= (n_count == keff);
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_kth;
    assign m_axis_tuser[0] = r_m_full;

endmodule

// ----- hw/rtl/klst_checker.sv -----
// Port-level checks for kth_largest_stream_tracker, attached by bind below.
// Depends on klst_pkg for field widths.
module klst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [klst_pkg::VALUE_W-1:0]  m_axis_tdata,
    input logic [0:0]                    m_axis_tuser
);
    import klst_pkg::*;

    // every input transaction yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("no result after input transaction");

    // no result appears without an input transaction behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && i_rst_n))
        else $error("result without input transaction");

    // an empty result stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result stage");

    // a stalled result holds its payload
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind kth_largest_stream_tracker klst_checker u_klst_checker (.*);
